[rtl/wsfe_pkg.sv]
`timescale 1ns / 1ps

package wsfe_pkg;

    localparam int unsigned LEN_W  = 63;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned POS_W  = 4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    localparam logic [BYTE_W-1:0] HDR_FIN_TEXT = 8'h81;
    localparam logic [BYTE_W-1:0] HDR_MASK_BIT = 8'h80;
    localparam logic [BYTE_W-1:0] HDR_LEN16    = 8'd126;
    localparam logic [BYTE_W-1:0] HDR_LEN64    = 8'd127;

    localparam logic [LEN_W-1:0] LIM_SHORT = 63'd126;
    localparam logic [LEN_W-1:0] LIM_MED   = 63'd65536;

    // Position of the last header byte for each length class.
    localparam logic [POS_W-1:0] LAST_POS_SHORT = 4'd5;
    localparam logic [POS_W-1:0] LAST_POS_MED   = 4'd7;
    localparam logic [POS_W-1:0] LAST_POS_LONG  = 4'd13;

    typedef enum logic [1:0] {
        CLS_SHORT = 2'd0,
        CLS_MED   = 2'd1,
        CLS_LONG  = 2'd2
    } t_len_cls;

    function automatic logic [BYTE_W-1:0] mask_byte(
        input logic [KEY_W-1:0] key,
        input logic [1:0]       idx
    );
        logic [BYTE_W-1:0] b;
        unique case (idx)
            2'd0:    b = key[31:24];
            2'd1:    b = key[23:16];
            2'd2:    b = key[15:8];
            default: b = key[7:0];
        endcase
        return b;
    endfunction

endpackage

[rtl/wsfe_if.sv]
`timescale 1ns / 1ps

interface wsfe_in_if;
    import wsfe_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [LEN_W-1:0]  frame_length;
    logic [KEY_W-1:0]  mask_key;
    logic [BYTE_W-1:0] payload_byte;

    modport source (output valid, kind, frame_length, mask_key, payload_byte,
                    input ready);
    modport sink   (input valid, kind, frame_length, mask_key, payload_byte,
                    output ready);
endinterface

interface wsfe_out_if;
    import wsfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_done;

    modport source (output valid, out_byte, run_last, frame_done, input ready);
    modport sink   (input valid, out_byte, run_last, frame_done, output ready);
endinterface

[rtl/websocket_frame_encoder.sv]
`timescale 1ns / 1ps

// Masked client-to-server frame encoder.
// i_req carries requests: a start request (kind 0) with the payload length and
// the mask key, or a data request (kind 1) with one payload byte. o_res gives
// the frame one byte per transfer, with run_last on the final byte caused by a
// request and frame_done on the final byte of the frame.
// A start request yields 6, 8 or 14 header bytes, one per cycle while o_res
// is ready, and holds the work register until the last of them is emitted.
// A data request yields one masked byte, and data requests are taken at one
// per cycle while o_res is ready. A data request with no frame open is
// absorbed without any output. A byte passes through the work register and
// then the output register before it is offered on o_res.
// When the receiver stalls, the output register holds its byte and the work
// register holds the pending request; i_req.ready drops once both are full.
// Reset (synchronous, active low) empties both registers and closes any frame.
module websocket_frame_encoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsfe_in_if.sink           i_req,
    wsfe_out_if.source        o_res
);
    import wsfe_pkg::*;

    logic              r_busy;
    logic              r_hdr;
    logic [POS_W-1:0]  r_pos;
    t_len_cls          r_cls;
    logic [LEN_W-1:0]  r_len;
    logic              r_len_zero;
    logic [KEY_W-1:0]  r_key;
    logic [BYTE_W-1:0] r_dbyte;
    logic              r_ddone;

    logic              r_ov;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_olast;
    logic              r_odone;

    logic [LEN_W-1:0]  r_left;
    logic [KEY_W-1:0]  r_mask;
    logic [1:0]        r_midx;
    logic              r_open;

    logic              w_emit;
    logic              w_hdr_last;
    logic              w_last;
    logic              w_acc;
    logic              w_start;
    logic              w_data;
    logic [POS_W-1:0]  w_last_pos;
    logic [BYTE_W-1:0] w_hdr_byte;
    logic [BYTE_W-1:0] w_len_byte;
    logic [63:0]       w_len64;
    logic [2:0]        w_len_sel;
    t_len_cls          w_in_cls;

    always_comb begin
        unique case (r_cls)
            CLS_SHORT: w_last_pos = LAST_POS_SHORT;
            CLS_MED:   w_last_pos = LAST_POS_MED;
            default:   w_last_pos = LAST_POS_LONG;
        endcase
    end

    assign w_emit     = r_busy && (!r_ov || o_res.ready);
    assign w_hdr_last = (r_pos == w_last_pos);
    assign w_last     = !r_hdr || w_hdr_last;

    assign i_req.ready = !r_busy || (w_emit && w_last);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_start     = w_acc && (i_req.kind == KIND_START);
    assign w_data      = w_acc && (i_req.kind == KIND_DATA) && r_open;

    always_comb begin
        if (i_req.frame_length < LIM_SHORT) begin
            w_in_cls = CLS_SHORT;
        end else if (i_req.frame_length < LIM_MED) begin
            w_in_cls = CLS_MED;
        end else begin
            w_in_cls = CLS_LONG;
        end
    end

    // Long form: byte j of the 64-bit big-endian length sits at header
    // position j + 2.
    assign w_len64   = {1'b0, r_len};
    assign w_len_sel = 3'(r_pos - 4'd2);
    always_comb begin
        unique case (w_len_sel)
            3'd0:    w_len_byte = w_len64[63:56];
            3'd1:    w_len_byte = w_len64[55:48];
            3'd2:    w_len_byte = w_len64[47:40];
            3'd3:    w_len_byte = w_len64[39:32];
            3'd4:    w_len_byte = w_len64[31:24];
            3'd5:    w_len_byte = w_len64[23:16];
            3'd6:    w_len_byte = w_len64[15:8];
            default: w_len_byte = w_len64[7:0];
        endcase
    end

    always_comb begin
        if (r_pos == 4'd0) begin
            w_hdr_byte = HDR_FIN_TEXT;
        end else begin
            unique case (r_cls)
                CLS_SHORT: begin
                    if (r_pos == 4'd1) begin
                        w_hdr_byte = HDR_MASK_BIT | {1'b0, r_len[6:0]};
                    end else begin
                        w_hdr_byte = mask_byte(r_key, 2'(r_pos - 4'd2));
                    end
                end
                CLS_MED: begin
                    if (r_pos == 4'd1) begin
                        w_hdr_byte = HDR_MASK_BIT | HDR_LEN16;
                    end else if (r_pos == 4'd2) begin
                        w_hdr_byte = r_len[15:8];
                    end else if (r_pos == 4'd3) begin
                        w_hdr_byte = r_len[7:0];
                    end else begin
                        w_hdr_byte = mask_byte(r_key, 2'(r_pos - 4'd4));
                    end
                end
                default: begin
                    if (r_pos == 4'd1) begin
                        w_hdr_byte = HDR_MASK_BIT | HDR_LEN64;
                    end else if (r_pos < 4'd10) begin
                        w_hdr_byte = w_len_byte;
                    end else begin
                        w_hdr_byte = mask_byte(r_key, 2'(r_pos - 4'd10));
                    end
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_hdr  <= 1'b0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
            r_left <= '0;
            r_mask <= '0;
            r_midx <= '0;
            r_open <= 1'b0;
        end else begin
            if (w_emit) begin
                r_pos <= r_pos + 4'd1;
                r_ov  <= 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            if (w_start) begin
                r_busy <= 1'b1;
                r_hdr  <= 1'b1;
                r_pos  <= '0;
                r_left <= i_req.frame_length;
                r_mask <= i_req.mask_key;
                r_midx <= '0;
                r_open <= (i_req.frame_length != '0);
            end else if (w_data) begin
                r_busy <= 1'b1;
                r_hdr  <= 1'b0;
                r_left <= r_left - 63'd1;
                r_midx <= r_midx + 2'd1;
                r_open <= (r_left != 63'd1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cls      <= w_in_cls;
            r_len      <= i_req.frame_length;
            r_len_zero <= (i_req.frame_length == '0);
            r_key      <= i_req.mask_key;
        end
        if (w_data) begin
            r_dbyte <= i_req.payload_byte ^ mask_byte(r_mask, r_midx);
            r_ddone <= (r_left == 63'd1);
        end
        if (w_emit) begin
            r_obyte <= r_hdr ? w_hdr_byte : r_dbyte;
            r_olast <= w_last;
            r_odone <= r_hdr ? (w_hdr_last && r_len_zero) : r_ddone;
        end
    end

    assign o_res.valid      = r_ov;
    assign o_res.out_byte   = r_obyte;
    assign o_res.run_last   = r_olast;
    assign o_res.frame_done = r_odone;

endmodule
